### src/pts_pkg.sv
package pts_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int ELAPSED_WIDTH = 32;

   // register field widths
   localparam int WINDOW_W = 16;
   localparam int PPR_W    = 8;
   localparam int DIST_W   = 10;
   localparam int RPM_W    = 16;
   localparam int SPEED_W  = 16;

   // constant operands
   localparam int TICKS_PER_MIN_W = 16;
   localparam int TICKS_PER_MIN   = 60000;
   localparam int KMH_DIVISOR     = 10000;
   localparam int DIST6_W         = DIST_W + 3;

   // widths of the serial datapath
   localparam int SPEED_PROD_W = RPM_W + DIST6_W;
   localparam int NUM_W = (COUNT_WIDTH + TICKS_PER_MIN_W > SPEED_PROD_W) ?
                          COUNT_WIDTH + TICKS_PER_MIN_W : SPEED_PROD_W;
   localparam int MPL_W = (COUNT_WIDTH > DIST6_W) ? COUNT_WIDTH : DIST6_W;
   localparam int DEN_W = ELAPSED_WIDTH + PPR_W;
   localparam int STEP_W = $clog2(NUM_W);

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_MS      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSES_PER_REV = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_PER_REV   = 2'd2;
   localparam int CSR_DATA_W = 16;

   // reset values of the registers
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
   localparam logic [PPR_W-1:0]    PPR_RESET    = 8'd20;
   localparam logic [DIST_W-1:0]   DIST_RESET   = 10'd136;

   // item kinds
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // commands from the sequencer to the serial arithmetic unit
   typedef struct packed {
      logic mul_load;
      logic mul_step;
      logic div_load;
      logic div_step;
   } ctrl_type;

endpackage

### src/pts_muldiv.sv
// shift-add multiplier pair feeding a restoring divider, one bit per step
module pts_muldiv (
   input  logic                       clock,
   input  pts_pkg::ctrl_type          ctrl,
   input  logic [pts_pkg::NUM_W-1:0]  num_mcand,
   input  logic [pts_pkg::MPL_W-1:0]  num_mplier,
   input  logic [pts_pkg::DEN_W-1:0]  den_mcand,
   input  logic [pts_pkg::PPR_W-1:0]  den_mplier,
   output logic [pts_pkg::NUM_W-1:0]  quotient
);

   logic [pts_pkg::NUM_W-1:0] acc_ff, acc_in;
   logic [pts_pkg::NUM_W-1:0] mcand_ff, mcand_in;
   logic [pts_pkg::MPL_W-1:0] mplier_ff, mplier_in;
   logic [pts_pkg::DEN_W-1:0] dacc_ff, dacc_in;
   logic [pts_pkg::DEN_W-1:0] dmcand_ff, dmcand_in;
   logic [pts_pkg::PPR_W-1:0] dmplier_ff, dmplier_in;
   logic [pts_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [pts_pkg::NUM_W-1:0] quo_ff, quo_in;
   logic [pts_pkg::DEN_W:0]   trial;
   logic [pts_pkg::DEN_W:0]   diff;

   // partial remainder with the next numerator bit shifted in
   assign trial = {rem_ff, quo_ff[pts_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, dacc_ff};

   always_comb begin
      acc_in     = acc_ff;
      mcand_in   = mcand_ff;
      mplier_in  = mplier_ff;
      dacc_in    = dacc_ff;
      dmcand_in  = dmcand_ff;
      dmplier_in = dmplier_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (ctrl.mul_load) begin
         acc_in     = '0;
         mcand_in   = num_mcand;
         mplier_in  = num_mplier;
         dacc_in    = '0;
         dmcand_in  = den_mcand;
         dmplier_in = den_mplier;
      end else if (ctrl.mul_step) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         if (dmplier_ff[0]) begin
            dacc_in = dacc_ff + dmcand_ff;
         end
         mcand_in   = {mcand_ff[pts_pkg::NUM_W-2:0], 1'b0};
         mplier_in  = {1'b0, mplier_ff[pts_pkg::MPL_W-1:1]};
         dmcand_in  = {dmcand_ff[pts_pkg::DEN_W-2:0], 1'b0};
         dmplier_in = {1'b0, dmplier_ff[pts_pkg::PPR_W-1:1]};
      end
      if (ctrl.div_load) begin
         rem_in = '0;
         quo_in = acc_ff;
      end else if (ctrl.div_step) begin
         // a zero divisor always subtracts, giving an all-ones quotient
         if (!diff[pts_pkg::DEN_W]) begin
            rem_in = diff[pts_pkg::DEN_W-1:0];
            quo_in = {quo_ff[pts_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[pts_pkg::DEN_W-1:0];
            quo_in = {quo_ff[pts_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplier_ff  <= mplier_in;
      dacc_ff    <= dacc_in;
      dmcand_ff  <= dmcand_in;
      dmplier_ff <= dmplier_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

### src/pulse_tachometer_speedometer_core.sv
// timing: a transaction that does not close a window finishes in the cycle it is accepted
// a closing tick gives its result after an rpm and then a speed multiply-divide pass
// throughput: one transaction per cycle, except that while a window result is being
// computed no transaction is taken; the bit-serial multiply and divide set that time,
// and a stalled result stream holds the block in its last step
// reset: synchronous, active high; clears both counts, the sequencer and the output valid
// flag, and loads window 1000, 20 pulses per rev and 136 cm per rev
module pulse_tachometer_speedometer_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] sensor_levels, [7:3] zero
   input  logic        req_tuser,   // operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] rev_per_minute, [31:16] speed_kmh
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pts_pkg::CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,  // accepting transactions
      ST_MUL   = 6'b000010,  // shift-add products
      ST_DLOAD = 6'b000100,  // numerator into the divider
      ST_DIV   = 6'b001000,  // restoring division
      ST_NEXT  = 6'b010000,  // rpm done, set up the speed product
      ST_OUT   = 6'b100000   // hand the result to the output register
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [pts_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [pts_pkg::PPR_W-1:0]    ppr_ff, ppr_in;
   logic [pts_pkg::DIST_W-1:0]   dist_ff, dist_in;

   // measurement state
   logic [pts_pkg::COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [pts_pkg::ELAPSED_WIDTH-1:0] elapsed_ff, elapsed_in;
   logic [pts_pkg::ELAPSED_WIDTH-1:0] elapsed_next;

   // sequencer
   logic [pts_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       phase_ff, phase_in;   // 0 rpm pass, 1 speed pass
   logic [pts_pkg::RPM_W-1:0]  rpm_ff, rpm_in;
   logic [pts_pkg::RPM_W-1:0]  rpm_sat;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff, rsp_data_in;

   // serial unit hookup
   pts_pkg::ctrl_type          ctrl;
   logic [pts_pkg::NUM_W-1:0]  num_mcand;
   logic [pts_pkg::MPL_W-1:0]  num_mplier;
   logic [pts_pkg::DEN_W-1:0]  den_mcand;
   logic [pts_pkg::PPR_W-1:0]  den_mplier;
   logic [pts_pkg::NUM_W-1:0]  quotient;
   logic [pts_pkg::DIST6_W-1:0] dist6;

   logic accept;
   logic edge_ok;
   logic emit;
   logic out_free;

   localparam logic [pts_pkg::STEP_W-1:0] MUL_LAST = pts_pkg::STEP_W'(pts_pkg::MPL_W - 1);
   localparam logic [pts_pkg::STEP_W-1:0] DIV_LAST = pts_pkg::STEP_W'(pts_pkg::NUM_W - 1);

   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   // active low levels: hall asserted and exactly one phase asserted
   assign edge_ok = !req_tdata[0] && (req_tdata[1] != req_tdata[2]);

   assign elapsed_next = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   // a tick closes the window once enough time has passed and something was counted
   assign emit = accept && (req_tuser == pts_pkg::OP_TICK) &&
                 (elapsed_next >= {{(pts_pkg::ELAPSED_WIDTH - pts_pkg::WINDOW_W){1'b0}},
                                   window_ff}) &&
                 (count_ff != '0);

   // rpm saturates when the quotient spills above 16 bits
   assign rpm_sat = (quotient[pts_pkg::NUM_W-1:pts_pkg::RPM_W] != '0) ?
                    '1 : quotient[pts_pkg::RPM_W-1:0];

   // distance times six, as 4x + 2x
   assign dist6 = ({3'b000, dist_ff} << 2) + ({3'b000, dist_ff} << 1);

   assign out_free = !rsp_valid_ff || rsp_tready;

   // operands: count*60000 over elapsed*ppr, then rpm*dist*6 over 10000
   always_comb begin
      if (state_ff == ST_NEXT) begin
         num_mcand  = {{(pts_pkg::NUM_W - pts_pkg::RPM_W){1'b0}}, rpm_sat};
         num_mplier = {{(pts_pkg::MPL_W - pts_pkg::DIST6_W){1'b0}}, dist6};
         den_mcand  = pts_pkg::DEN_W'(pts_pkg::KMH_DIVISOR);
         den_mplier = pts_pkg::PPR_W'(1);
      end else begin
         num_mcand  = pts_pkg::NUM_W'(pts_pkg::TICKS_PER_MIN);
         num_mplier = {{(pts_pkg::MPL_W - pts_pkg::COUNT_WIDTH){1'b0}}, count_ff};
         den_mcand  = {{pts_pkg::PPR_W{1'b0}}, elapsed_next};
         den_mplier = ppr_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      ppr_in       = ppr_ff;
      dist_in      = dist_ff;
      count_in     = count_ff;
      elapsed_in   = elapsed_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      rpm_in       = rpm_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            pts_pkg::CSR_WINDOW_MS:      window_in = csr_data[pts_pkg::WINDOW_W-1:0];
            pts_pkg::CSR_PULSES_PER_REV: ppr_in    = csr_data[pts_pkg::PPR_W-1:0];
            pts_pkg::CSR_DIST_PER_REV:   dist_in   = csr_data[pts_pkg::DIST_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == pts_pkg::OP_EDGE) begin
                  if (edge_ok && count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
               end else if (emit) begin
                  // operands are latched in the serial unit, so the counts restart now
                  ctrl.mul_load = 1'b1;
                  count_in      = '0;
                  elapsed_in    = '0;
                  step_in       = '0;
                  phase_in      = 1'b0;
                  state_in      = ST_MUL;
               end else begin
                  elapsed_in = elapsed_next;
               end
            end
         end
         ST_MUL: begin
            ctrl.mul_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == MUL_LAST) begin
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            ctrl.div_load = 1'b1;
            step_in       = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            ctrl.div_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               state_in = phase_ff ? ST_OUT : ST_NEXT;
            end
         end
         ST_NEXT: begin
            rpm_in        = rpm_sat;
            ctrl.mul_load = 1'b1;
            step_in       = '0;
            phase_in      = 1'b1;
            state_in      = ST_MUL;
         end
         ST_OUT: begin
            // speed always fits in 16 bits
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {quotient[pts_pkg::SPEED_W-1:0], rpm_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= pts_pkg::WINDOW_RESET;
         ppr_ff       <= pts_pkg::PPR_RESET;
         dist_ff      <= pts_pkg::DIST_RESET;
         count_ff     <= '0;
         elapsed_ff   <= '0;
         step_ff      <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         ppr_ff       <= ppr_in;
         dist_ff      <= dist_in;
         count_ff     <= count_in;
         elapsed_ff   <= elapsed_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rpm_ff      <= rpm_in;
      rsp_data_ff <= rsp_data_in;
   end

   pts_muldiv u_muldiv (
      .clock      (clock),
      .ctrl       (ctrl),
      .num_mcand  (num_mcand),
      .num_mplier (num_mplier),
      .den_mcand  (den_mcand),
      .den_mplier (den_mplier),
      .quotient   (quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
